// ===== hdl/lcpr_pkg.sv =====
package lcpr_pkg;

	// Default sizes of the table.
	localparam int ENTRIES_DEF    = 16;
	localparam int PAGE_BITS_DEF  = 20;
	localparam int STAMP_BITS_DEF = 32;

	// Fixed widths of the words on the ports.
	localparam int PAGE_IN_W = 20;
	localparam int EVICT_W   = 20;
	localparam int OUTCOME_W = 2;
	localparam int CAP_W     = 5;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Outcome codes of a result word.
	localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_FILL    = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_REPLACE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic fast;
	} sts_t;

endpackage

// ===== hdl/lcpr_req_if.sv =====
interface lcpr_req_if;

	logic                             valid;
	logic                             ready;
	logic [lcpr_pkg::PAGE_IN_W-1:0]   page_number;

	modport source (output valid, output page_number, input ready);
	modport sink (input valid, input page_number, output ready);

endinterface

// ===== hdl/lcpr_rsp_if.sv =====
interface lcpr_rsp_if;

	logic                             valid;
	logic                             ready;
	logic [lcpr_pkg::OUTCOME_W-1:0]   outcome;
	logic [lcpr_pkg::EVICT_W-1:0]     evicted_page;
	logic                             evicted_valid;

	modport source (output valid, output outcome, output evicted_page, output evicted_valid,
		input ready);
	modport sink (input valid, input outcome, input evicted_page, input evicted_valid,
		output ready);

endinterface

// ===== hdl/lcpr_ctrl.sv =====
module lcpr_ctrl #(
	parameter int ENTRIES = lcpr_pkg::ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lcpr_pkg::sts_t    sts,
	output lcpr_pkg::cmd_t    cmd
);

	// The minimum tree settles one level per cycle after the leaves load.
	localparam int TREE_LAT = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(TREE_LAT + 2);

	localparam logic [0:0] ST_IDLE    = 1'b0;
	localparam logic [0:0] ST_RESOLVE = 1'b1;

	logic [0:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             commit_now;

	// A word is taken only while no reference is being resolved.
	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;

	// Hits and fills finish at once; a replacement waits for the tree root.
	assign commit_now = (state_q == ST_RESOLVE) && sts.out_free &&
		(sts.fast || (cnt_q == '0));
	assign cmd.commit = commit_now;

	// Sequencer state and tree wait counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_RESOLVE;
						cnt_q   <= CNT_W'(TREE_LAT);
					end
				end
				ST_RESOLVE: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
					if (commit_now) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/lcpr_datapath.sv =====
module lcpr_datapath #(
	parameter int ENTRIES    = lcpr_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS  = lcpr_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lcpr_pkg::STAMP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lcpr_pkg::cmd_t                   cmd,
	output lcpr_pkg::sts_t                   sts,
	input  logic [lcpr_pkg::PAGE_IN_W-1:0]   page_number,
	input  logic                             cfg_we,
	input  logic [lcpr_pkg::CAP_W-1:0]       cfg_wdata,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lcpr_pkg::OUTCOME_W-1:0]   outcome,
	output logic [lcpr_pkg::EVICT_W-1:0]     evicted_page,
	output logic                             evicted_valid
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LEVELS = $clog2(ENTRIES);
	localparam int LEAVES = 1 << LEVELS;
	localparam int NODES  = 2 * LEAVES - 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > lcpr_pkg::CAP_W) ? OCC_W : lcpr_pkg::CAP_W;

	// One candidate of the minimum search.
	typedef struct packed {
		logic                  vld;
		logic [STAMP_BITS-1:0] stamp;
		logic [PAGE_BITS-1:0]  page;
		logic [IDX_W-1:0]      idx;
	} node_t;

	// Older stamp wins; on equal stamps the lower page number wins.
	function automatic node_t pick(input node_t a, input node_t b);
		node_t r;
		if (!b.vld) begin
			r = a;
		end else if (!a.vld) begin
			r = b;
		end else if (a.stamp < b.stamp) begin
			r = a;
		end else if ((a.stamp == b.stamp) && (a.page <= b.page)) begin
			r = a;
		end else begin
			r = b;
		end
		return r;
	endfunction

	// Table and global state.
	logic                  slot_valid_q [ENTRIES];
	logic [PAGE_BITS-1:0]  slot_page_q  [ENTRIES];
	logic [STAMP_BITS-1:0] slot_stamp_q [ENTRIES];
	logic [STAMP_BITS-1:0] time_q;
	logic [OCC_W-1:0]      occ_q;
	logic [lcpr_pkg::CAP_W-1:0] cap_q;

	// Registers of the reference in flight.
	logic [PAGE_BITS-1:0]  page_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic                  free_any_q;
	logic [IDX_W-1:0]      free_idx_q;

	// Minimum tree, heap ordered with the root at index zero.
	node_t                 node_q [NODES];
	node_t                 leaf_d [LEAVES];

	logic [PAGE_BITS-1:0]  page_in;
	logic                  match_any;
	logic [IDX_W-1:0]      match_idx;
	logic                  free_any;
	logic [IDX_W-1:0]      free_idx;

	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      eff_cap;
	logic                  fill_ok;
	node_t                 root;
	logic [IDX_W-1:0]      wr_idx;
	logic                  wr_page;
	logic                  set_valid;
	logic [OCC_W-1:0]      occ_d;
	logic [lcpr_pkg::OUTCOME_W-1:0] outcome_d;
	logic [lcpr_pkg::EVICT_W-1:0]   ev_page_d;
	logic                  ev_valid_d;

	logic                  out_valid_q;
	logic [lcpr_pkg::OUTCOME_W-1:0] outcome_q;
	logic [lcpr_pkg::EVICT_W-1:0]   ev_page_q;
	logic                  ev_valid_q;

	assign page_in = PAGE_BITS'(page_number);

	// Parallel tag compare and lowest free slot on the incoming page.
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			if (slot_valid_q[j] && (slot_page_q[j] == page_in)) begin
				match_any = 1'b1;
				match_idx = match_idx | IDX_W'(j);
			end
		end
		for (int j = ENTRIES - 1; j >= 0; j--) begin
			if (!slot_valid_q[j]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(j);
			end
		end
	end

	// Leaves of the tree; padding leaves never win.
	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < ENTRIES) begin : g_used
			assign leaf_d[j] = '{vld: slot_valid_q[j], stamp: slot_stamp_q[j],
				page: slot_page_q[j], idx: IDX_W'(j)};
		end else begin : g_pad
			assign leaf_d[j] = '0;
		end
	end

	// The leaves load with the reference; each level settles in the cycle after the level below it.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int j = 0; j < LEAVES; j++) begin
				node_q[LEAVES - 1 + j] <= leaf_d[j];
			end
		end
		for (int n = 0; n < LEAVES - 1; n++) begin
			node_q[n] <= pick(node_q[2 * n + 1], node_q[2 * n + 2]);
		end
	end

	// Lookup results held for the resolve step.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q     <= page_in;
			hit_q      <= match_any;
			hit_idx_q  <= match_idx;
			free_any_q <= free_any;
			free_idx_q <= free_idx;
		end
	end

	// Capacity clamped to the range one to the entry count.
	assign cap_ext = CMP_W'(cap_q);
	assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
		((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);

	assign fill_ok = !hit_q && free_any_q && (CMP_W'(occ_q) < eff_cap);
	assign root    = node_q[0];

	// Choose the slot to write and the result word.
	always_comb begin
		wr_idx     = hit_idx_q;
		wr_page    = 1'b0;
		set_valid  = 1'b0;
		occ_d      = occ_q;
		outcome_d  = lcpr_pkg::OUT_HIT;
		ev_page_d  = '0;
		ev_valid_d = 1'b0;
		if (hit_q) begin
			wr_idx = hit_idx_q;
		end else if (fill_ok) begin
			wr_idx    = free_idx_q;
			wr_page   = 1'b1;
			set_valid = 1'b1;
			occ_d     = OCC_W'(occ_q + 1'b1);
			outcome_d = lcpr_pkg::OUT_FILL;
		end else if (root.vld) begin
			wr_idx     = root.idx;
			wr_page    = 1'b1;
			outcome_d  = lcpr_pkg::OUT_REPLACE;
			ev_page_d  = lcpr_pkg::EVICT_W'(root.page);
			ev_valid_d = 1'b1;
		end else begin
			// An empty table with no free room cannot arise; take slot zero.
			wr_idx    = '0;
			wr_page   = 1'b1;
			set_valid = 1'b1;
			occ_d     = OCC_W'(1);
			outcome_d = lcpr_pkg::OUT_FILL;
		end
	end

	assign sts.fast     = hit_q || fill_ok;
	assign sts.out_free = !out_valid_q || out_ready;

	// Page and stamp of each slot.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_stamp_q[wr_idx] <= time_q;
			if (wr_page) begin
				slot_page_q[wr_idx] <= page_q;
			end
		end
	end

	// Valid bits, fill count, saturating timer and capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ENTRIES; j++) begin
				slot_valid_q[j] <= 1'b0;
			end
			occ_q  <= '0;
			time_q <= '0;
			cap_q  <= lcpr_pkg::CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.capture && (time_q != '1)) begin
				time_q <= time_q + 1'b1;
			end
			if (cmd.commit) begin
				occ_q <= occ_d;
				if (set_valid) begin
					slot_valid_q[wr_idx] <= 1'b1;
				end
			end
		end
	end

	// Output register holding the result word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			outcome_q  <= outcome_d;
			ev_page_q  <= ev_page_d;
			ev_valid_q <= ev_valid_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign evicted_page  = ev_page_q;
	assign evicted_valid = ev_valid_q;

endmodule

// ===== hdl/lru_counter_page_replacer_top.sv =====
// Fully associative page table with least-recently-used replacement by
// timestamps. Each request word carries one page reference and yields one
// result word: a hit, a fault that filled the lowest free slot, or a fault
// that replaced the slot with the oldest stamp (lowest page on a tie), with
// the evicted page. Every reference advances a saturating timer and stamps
// its page. A hit or fill is committed to the result register from the
// resolve state once that register is free; the sequencer then returns to
// idle to take the next request. A replacement waits for the registered minimum
// tree over the slot stamps, one level a cycle, before it is committed. No new
// request is taken until the current reference is committed. A result word
// that is still waiting holds the next commit back. A new request is taken
// while an earlier result still waits to be read. The capacity register
// (reset 16) is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Zero acts as one and values above ENTRIES as ENTRIES.
module lru_counter_page_replacer_top #(
	parameter int ENTRIES    = lcpr_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS  = lcpr_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lcpr_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lcpr_req_if.sink                      request,
	lcpr_rsp_if.source                    result,
	input  logic                          cfg_we,
	input  logic [lcpr_pkg::CAP_W-1:0]    cfg_wdata
);

	lcpr_pkg::cmd_t cmd;
	lcpr_pkg::sts_t sts;

	// Sequencer.
	lcpr_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, minimum tree and result register.
	lcpr_datapath #(
		.ENTRIES    (ENTRIES),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.page_number   (request.page_number),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.outcome       (result.outcome),
		.evicted_page  (result.evicted_page),
		.evicted_valid (result.evicted_valid)
	);

	// Only one reference is resolved at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("request taken while a reference is being resolved");

	// The eviction flag goes with the replacement outcome only.
	a_evict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.evicted_valid == (result.outcome == lcpr_pkg::OUT_REPLACE)))
		else $error("eviction flag does not match the outcome");

	// Without an eviction the evicted page reads as zero.
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.evicted_valid) |-> (result.evicted_page == '0))
		else $error("evicted page is not zero without an eviction");

	// Only the three defined outcome codes appear.
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.outcome == lcpr_pkg::OUT_HIT) ||
			(result.outcome == lcpr_pkg::OUT_FILL) ||
			(result.outcome == lcpr_pkg::OUT_REPLACE)))
		else $error("undefined outcome code");

endmodule

// ===== bench/tb_lru_counter_page_replacer_top.sv =====
`timescale 1ns / 100ps

module tb_lru_counter_page_replacer_top;

	localparam int SLOTS          = lcpr_pkg::ENTRIES_DEF;
	localparam int STAMP_W        = lcpr_pkg::STAMP_BITS_DEF;
	localparam int PHASES         = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;

	// One result word as the table lookup should produce it.
	typedef struct packed {
		logic [lcpr_pkg::OUTCOME_W-1:0] outcome;
		logic [lcpr_pkg::EVICT_W-1:0]   evicted_page;
		logic                           evicted_valid;
	} page_ref_rsp_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [lcpr_pkg::CAP_W-1:0] cfg_wdata;

	lcpr_req_if req_ch ();
	lcpr_rsp_if rsp_ch ();

	lru_counter_page_replacer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (req_ch),
		.result    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the page table.
	logic                           pt_valid [SLOTS];
	logic [lcpr_pkg::PAGE_IN_W-1:0] pt_page  [SLOTS];
	logic [STAMP_W-1:0]             pt_stamp [SLOTS];
	logic [STAMP_W-1:0]             pt_clock;
	int unsigned                    pt_count;
	logic [lcpr_pkg::CAP_W-1:0]     pt_capacity;

	logic [lcpr_pkg::PAGE_IN_W-1:0] pending_pages [$];
	page_ref_rsp_t                  expected_outcomes [$];
	int unsigned                    issued_total;
	int unsigned                    accepted_total;
	int unsigned                    error_count;
	int unsigned                    stall_cycles;
	logic                           req_fire;
	int unsigned                    send_idle_pct;
	int unsigned                    recv_idle_pct;

	// Working set of pages for the random part.
	logic [lcpr_pkg::PAGE_IN_W-1:0] page_pool [24];
	int unsigned                    pool_span;

	page_ref_rsp_t got_rsp;
	page_ref_rsp_t want_rsp;

	// Look up one page reference in the shadow table and update it.
	task automatic predict_reference(input logic [lcpr_pkg::PAGE_IN_W-1:0] page);
		page_ref_rsp_t rsp;
		int            slot;
		int unsigned   eff_cap;
		rsp  = '0;
		slot = -1;
		rsp.outcome = lcpr_pkg::OUT_HIT;
		if (pt_clock != '1) begin
			pt_clock = pt_clock + 1'b1;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (slot < 0 && pt_valid[i] && pt_page[i] == page) begin
				slot = i;
			end
		end
		if (slot < 0) begin
			eff_cap = pt_capacity;
			if (eff_cap < 1) begin
				eff_cap = 1;
			end
			if (eff_cap > SLOTS) begin
				eff_cap = SLOTS;
			end
			// Fill the lowest free slot while below capacity.
			if (pt_count < eff_cap) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot < 0 && !pt_valid[i]) begin
						slot = i;
					end
				end
				if (slot >= 0) begin
					pt_valid[slot] = 1'b1;
					pt_count++;
					rsp.outcome = lcpr_pkg::OUT_FILL;
				end
			end
			// Otherwise evict the oldest stamp, lowest page on a tie.
			if (slot < 0) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (pt_valid[i]) begin
						if (slot < 0 || pt_stamp[i] < pt_stamp[slot] ||
							(pt_stamp[i] == pt_stamp[slot] && pt_page[i] < pt_page[slot])) begin
							slot = i;
						end
					end
				end
				if (slot < 0) begin
					slot = 0;
					pt_valid[0] = 1'b1;
					pt_count = 1;
					rsp.outcome = lcpr_pkg::OUT_FILL;
				end else begin
					rsp.evicted_page  = pt_page[slot];
					rsp.evicted_valid = 1'b1;
					rsp.outcome       = lcpr_pkg::OUT_REPLACE;
				end
			end
			pt_page[slot] = page;
		end
		pt_stamp[slot] = pt_clock;
		expected_outcomes.push_back(rsp);
	endtask

	task automatic queue_page(input logic [lcpr_pkg::PAGE_IN_W-1:0] page);
		pending_pages.push_back(page);
		issued_total++;
	endtask

	// Mostly pages from the working set, some fully random ones.
	function automatic logic [lcpr_pkg::PAGE_IN_W-1:0] pick_page();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) begin
			return page_pool[$urandom_range(0, pool_span - 1)];
		end else if (roll < 85) begin
			return page_pool[$urandom_range(0, 3)];
		end
		return lcpr_pkg::PAGE_IN_W'($urandom_range(0, (1 << lcpr_pkg::PAGE_IN_W) - 1));
	endfunction

	task automatic wait_drained();
		while (accepted_total != issued_total || expected_outcomes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_capacity(input logic [lcpr_pkg::CAP_W-1:0] value);
		repeat (8) @(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		pt_capacity  = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Request driver: presents the next pending word at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_fire) begin
				if (pending_pages.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_ch.valid       <= 1'b1;
					req_ch.page_number <= pending_pages.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts accepted requests and checks accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				predict_reference(req_ch.page_number);
				accepted_total <= accepted_total + 1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp.outcome       = rsp_ch.outcome;
				got_rsp.evicted_page  = rsp_ch.evicted_page;
				got_rsp.evicted_valid = rsp_ch.evicted_valid;
				if (expected_outcomes.size() == 0) begin
					$error("result word with no reference pending: outcome %0d", got_rsp.outcome);
					error_count++;
				end else begin
					want_rsp = expected_outcomes.pop_front();
					if (got_rsp.outcome !== want_rsp.outcome) begin
						$error("outcome mismatch: expected %0d, actual %0d",
							want_rsp.outcome, got_rsp.outcome);
						error_count++;
					end
					if (got_rsp.evicted_page !== want_rsp.evicted_page) begin
						$error("evicted_page mismatch: expected %h, actual %h",
							want_rsp.evicted_page, got_rsp.evicted_page);
						error_count++;
					end
					if (got_rsp.evicted_valid !== want_rsp.evicted_valid) begin
						$error("evicted_valid mismatch: expected %0d, actual %0d",
							want_rsp.evicted_valid, got_rsp.evicted_valid);
						error_count++;
					end
				end
			end
			// Watchdog on cycles without any accepted word.
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Stimulus: phases of capacity settings and handshake pressure.
	initial begin
		logic [lcpr_pkg::CAP_W-1:0] cap_plan  [PHASES];
		int unsigned                rand_plan [PHASES];
		cap_plan  = '{lcpr_pkg::CAP_RESET, 5'd0, 5'd8, 5'd17, 5'd2, 5'd31, 5'd16, 5'd1};
		rand_plan = '{0, 150, 150, 200, 250, 250, 250, 250};

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.page_number = '0;
		rsp_ch.ready       = 1'b0;
		req_fire           = 1'b0;
		issued_total       = 0;
		accepted_total     = 0;
		error_count        = 0;
		stall_cycles       = 0;
		send_idle_pct      = 31;
		recv_idle_pct      = 61;
		pool_span          = 8;
		for (int i = 0; i < SLOTS; i++) begin
			pt_valid[i] = 1'b0;
			pt_page[i]  = '0;
			pt_stamp[i] = '0;
		end
		pt_clock    = '0;
		pt_count    = 0;
		pt_capacity = lcpr_pkg::CAP_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 31;
				recv_idle_pct = 61;
			end else if (ph < 6) begin
				send_idle_pct = 61;
				recv_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph != 0) begin
				write_capacity(cap_plan[ph]);
			end
			for (int i = 0; i < 24; i++) begin
				page_pool[i] = lcpr_pkg::PAGE_IN_W'($urandom_range(0,
					(1 << lcpr_pkg::PAGE_IN_W) - 1));
			end
			pool_span = $urandom_range(6, 24);

			// Reset capacity: fills, hits, and the extreme page numbers.
			if (ph == 0) begin
				queue_page('0);
				queue_page('1);
				queue_page('0);
				queue_page(20'h12345);
				queue_page(20'hAAAAA);
				queue_page(20'h55555);
				queue_page('1);
				queue_page(20'h00001);
			end
			// Capacity of zero while six pages are held: misses replace the oldest.
			if (ph == 1) begin
				queue_page(20'h80000);
				queue_page(20'h00001);
				queue_page(20'h7FFFF);
				queue_page('0);
				queue_page(20'h80000);
			end
			for (int n = 0; n < rand_plan[ph]; n++) begin
				queue_page(pick_page());
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
